// File: hdl/rhsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSI conversion package
// Shared constants, the arctangent table and the flag bundle that travels
// alongside each item through the divider and CORDIC pipelines.
// ----------------------------------------------------------------------------
package rhsi_pkg;

  // Default component width and the reset value of the full-scale register.
  localparam int          COMPONENT_BITS_DEF = 8;
  localparam logic [7:0]  MAX_VALUE_RESET    = 8'd255;

  // Fraction bits of every result.
  localparam int Q_BITS = 16;

  // CORDIC geometry: angles are in units of 2^-24 turn.
  localparam int           CORDIC_STEPS = 22;
  localparam int           ZW           = 26;
  localparam logic [16:0]  SQRT3_Q16    = 17'd113512;
  localparam logic [24:0]  QUARTER_TURN = 25'd4194304;
  localparam logic [24:0]  HALF_TURN    = 25'd8388608;
  localparam logic [24:0]  FULL_TURN    = 25'd16777216;
  localparam logic [24:0]  HUE_ROUND    = 25'd128;

  // atan(2^-i) in units of 2^-24 turn.
  localparam logic [22:0] ATAN_TURNS [CORDIC_STEPS] = '{
    23'd2097152, 23'd1238021, 23'd654136, 23'd332050, 23'd166669, 23'd83416,
    23'd41718,   23'd20860,   23'd10430,  23'd5215,   23'd2608,   23'd1304,
    23'd652,     23'd326,     23'd163,    23'd81,     23'd41,     23'd20,
    23'd10,      23'd5,       23'd3,      23'd1
  };

  // Per-item flags carried beside the data path.
  typedef struct packed {
    logic x_neg;     // chroma x component is negative
    logic g_lt_b;    // green below blue, hue lies in the upper half turn
    logic gray;      // all three components equal
    logic int_sat;   // intensity quotient overflows 16 bits
    logic sat_full;  // saturation quotient overflows 16 bits
    logic sum_zero;  // black pixel
  } rhsi_flags_t;

  localparam int FLAGS_W = $bits(rhsi_flags_t);

endpackage

// File: hdl/rhsi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-lane pipelined divider
// Restoring division, one quotient bit per stage, 16 stages. Each lane
// divides {hi, low} by den where hi < den, giving a 16-bit quotient.
// ----------------------------------------------------------------------------
module rhsi_div #(
  parameter int DW = 10,
  parameter int SW = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [1:0][DW-1:0]                     in_hi,
  input  logic [1:0][DW-1:0]                     in_den,
  input  logic [1:0][rhsi_pkg::Q_BITS-1:0]       in_low,
  input  logic [SW-1:0]                          in_side,
  output logic                                   out_valid,
  output logic [1:0][rhsi_pkg::Q_BITS-1:0]       out_q,
  output logic [SW-1:0]                          out_side
);
  import rhsi_pkg::*;

  logic                         v    [0:Q_BITS];
  logic [1:0][DW-1:0]           rem  [0:Q_BITS];
  logic [1:0][DW-1:0]           den  [0:Q_BITS];
  logic [1:0][Q_BITS-1:0]       low  [0:Q_BITS];
  logic [1:0][Q_BITS-1:0]       quo  [0:Q_BITS];
  logic [SW-1:0]                side [0:Q_BITS];

  // Stage zero is the input.
  assign v[0]    = in_valid;
  assign rem[0]  = in_hi;
  assign den[0]  = in_den;
  assign low[0]  = in_low;
  assign quo[0]  = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    logic [1:0][DW:0] sh;
    logic [1:0][DW:0] df;
    logic [1:0]       ge;

    // Bring down the next dividend bit and trial-subtract the divisor.
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sh[l] = {rem[k][l], low[k][l][Q_BITS-1]};
        df[l] = sh[l] - {1'b0, den[k][l]};
        ge[l] = (sh[l] >= {1'b0, den[k][l]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          rem[k+1][l] <= ge[l] ? df[l][DW-1:0] : sh[l][DW-1:0];
          low[k+1][l] <= {low[k][l][Q_BITS-2:0], 1'b0};
          quo[k+1][l] <= {quo[k][l][Q_BITS-2:0], ge[l]};
          den[k+1][l] <= den[k][l];
        end
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = v[Q_BITS];
  assign out_q     = quo[Q_BITS];
  assign out_side  = side[Q_BITS];

endmodule

// File: hdl/rhsi_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// One rotation per stage, 22 stages. Drives a first-quadrant vector onto
// the x axis and accumulates its angle in units of 2^-24 turn.
// ----------------------------------------------------------------------------
module rhsi_cordic #(
  parameter int CW = 28,
  parameter int SW = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [CW-1:0]              in_x,
  input  logic signed [CW-1:0]              in_y,
  input  logic [SW-1:0]                     in_side,
  output logic                              out_valid,
  output logic signed [rhsi_pkg::ZW-1:0]    out_z,
  output logic [SW-1:0]                     out_side
);
  import rhsi_pkg::*;

  logic                 v    [0:CORDIC_STEPS];
  logic signed [CW-1:0] x    [0:CORDIC_STEPS];
  logic signed [CW-1:0] y    [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z    [0:CORDIC_STEPS];
  logic [SW-1:0]        side [0:CORDIC_STEPS];

  assign v[0]    = in_valid;
  assign x[0]    = in_x;
  assign y[0]    = in_y;
  assign z[0]    = '0;
  assign side[0] = in_side;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] ang;
    logic signed [CW-1:0] ny;

    // Shifts truncate toward zero; x never goes negative.
    always_comb begin
      ny  = -y[i];
      dx  = (y[i] >= 0) ? (y[i] >>> i) : -(ny >>> i);
      dy  = x[i] >>> i;
      ang = signed'(ZW'(ATAN_TURNS[i]));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    // Rotate toward the axis; a vector already on the axis stays put.
    always_ff @(posedge clk) begin
      if (en) begin
        if (y[i] > 0) begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + ang;
        end else if (y[i] < 0) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - ang;
        end else begin
          x[i+1] <= x[i];
          y[i+1] <= y[i];
          z[i+1] <= z[i];
        end
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = v[CORDIC_STEPS];
  assign out_z     = z[CORDIC_STEPS];
  assign out_side  = side[CORDIC_STEPS];

endmodule

// File: hdl/rgb_to_hsi_pixel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSI pixel converter
// Converts one RGB pixel per clock, while the output is not stalled, into
// hue, saturation and intensity as unsigned Q0.16 fractions.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_t* stream, red in the lowest bits. Results leave on
//   the m_t* stream: hue, saturation, intensity in m_tdata from the lowest
//   bits up, and the hue-defined flag in m_tuser.
//   The full-scale register is written through cfg_valid/cfg_data while the
//   block is idle; cfg_ready is always high. A zero is treated as one.
//   Throughput is one item per cycle while no stall holds the pipeline. An
//   accepted item passes one preparation stage, 16 divider stages (one quotient
//   bit each), 22 CORDIC stages (one rotation each) and the output register.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken, so s_tready follows m_tready while a result waits;
//   a stall holds every item in place, nothing is lost or repeated.
//   Reset empties the pipeline and sets the full-scale register to 255.
// ----------------------------------------------------------------------------
module rgb_to_hsi_pixel_top #(
  parameter int COMPONENT_BITS = rhsi_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // Configuration: full-scale component value.
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [7:0]                                 cfg_data,
  // Pixel input; tdata: red_level, green_level, blue_level.
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0]      s_tdata,
  // Result output; tdata: hue, saturation, intensity; tuser: hue_defined.
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  output logic [3*rhsi_pkg::Q_BITS-1:0]              m_tdata,
  output logic                                       m_tuser
);
  import rhsi_pkg::*;

  localparam int CB    = COMPONENT_BITS;
  localparam int SUM_W = CB + 2;
  localparam int DEN_W = 10;
  localparam int DW    = (SUM_W > DEN_W) ? SUM_W : DEN_W;
  localparam int CW    = CB + 20;
  localparam int SW1   = 2 * CW + FLAGS_W;
  localparam int SW2   = 2 * Q_BITS + FLAGS_W;

  logic en;

  // Full-scale register, kept as the intensity divisor 3*max_value.
  logic [DEN_W-1:0] den_int;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      den_int <= DEN_W'(3 * MAX_VALUE_RESET);
    end else if (cfg_valid) begin
      den_int <= (cfg_data == 8'd0) ? DEN_W'(3) : DEN_W'(3 * cfg_data);
    end
  end

  // Pipeline moves whenever the output register can take a new item.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Preparation: sums, minimum, chroma vector and divider operands.
  logic [CB-1:0]         r, g, b, mn;
  logic [SUM_W-1:0]      sum, num_s, three_mn;
  logic [DW+Q_BITS-1:0]  half_w;
  logic [DW:0]           hi_s;
  logic signed [CB+2:0]  xs;
  logic [CB+1:0]         ax;
  logic signed [CB:0]    dgb;
  logic [CB-1:0]         ady;
  logic [CB+16:0]        ay;
  rhsi_flags_t           flg;

  always_comb begin
    r        = s_tdata[CB-1:0];
    g        = s_tdata[2*CB-1:CB];
    b        = s_tdata[3*CB-1:2*CB];
    sum      = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
    mn       = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    three_mn = SUM_W'({mn, 1'b0}) + SUM_W'(mn);
    num_s    = sum - three_mn;
    half_w   = (DW+Q_BITS)'(sum >> 1);
    hi_s     = (DW+1)'(num_s) + (DW+1)'(half_w[DW+Q_BITS-1:Q_BITS]);
    xs       = signed'((CB+3)'({r, 1'b0})) - signed'((CB+3)'(g))
               - signed'((CB+3)'(b));
    ax       = xs[CB+2] ? (CB+2)'(-xs) : (CB+2)'(xs);
    dgb      = signed'((CB+1)'(g)) - signed'((CB+1)'(b));
    ady      = dgb[CB] ? CB'(-dgb) : CB'(dgb);
    ay       = (CB+17)'(ady) * (CB+17)'(SQRT3_Q16);
    flg.x_neg    = xs[CB+2];
    flg.g_lt_b   = (g < b);
    flg.gray     = (r == g) && (g == b);
    flg.int_sat  = (DW'(sum) >= DW'(den_int));
    flg.sat_full = (hi_s >= (DW+1)'(sum));
    flg.sum_zero = (sum == '0);
  end

  // Preparation register.
  logic                    p_valid;
  logic [1:0][DW-1:0]      p_hi, p_den;
  logic [1:0][Q_BITS-1:0]  p_low;
  logic [SW1-1:0]          p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Lane 0: intensity, lane 1: saturation.
      p_hi[0]  <= DW'(sum);
      p_den[0] <= DW'(den_int);
      p_low[0] <= Q_BITS'(den_int >> 1);
      p_hi[1]  <= hi_s[DW-1:0];
      p_den[1] <= DW'(sum);
      p_low[1] <= half_w[Q_BITS-1:0];
      p_side   <= {flg, CW'({ay}), CW'({ax, 16'd0})};
    end
  end

  // Divider pipeline.
  logic                    d_valid;
  logic [1:0][Q_BITS-1:0]  d_q;
  logic [SW1-1:0]          d_side;

  rhsi_div #(
    .DW (DW),
    .SW (SW1)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .in_hi     (p_hi),
    .in_den    (p_den),
    .in_low    (p_low),
    .in_side   (p_side),
    .out_valid (d_valid),
    .out_q     (d_q),
    .out_side  (d_side)
  );

  // CORDIC pipeline; the quotients ride along.
  logic                 c_valid;
  logic signed [ZW-1:0] c_z;
  logic [SW2-1:0]       c_side;

  rhsi_cordic #(
    .CW (CW),
    .SW (SW2)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_x      (signed'(d_side[CW-1:0])),
    .in_y      (signed'(d_side[2*CW-1:CW])),
    .in_side   ({d_side[SW1-1:2*CW], d_q[1], d_q[0]}),
    .out_valid (c_valid),
    .out_z     (c_z),
    .out_side  (c_side)
  );

  // Final assembly: angle folding, rounding and saturation.
  rhsi_flags_t       fo;
  logic [24:0]       phi, theta, h24, hr;
  logic [Q_BITS-1:0] hue_n, sat_n, int_n, q_int, q_sat;

  always_comb begin
    fo    = rhsi_flags_t'(c_side[SW2-1:2*Q_BITS]);
    q_int = c_side[Q_BITS-1:0];
    q_sat = c_side[2*Q_BITS-1:Q_BITS];
    if (c_z < 0) begin
      phi = '0;
    end else if (c_z > signed'(ZW'(QUARTER_TURN))) begin
      phi = QUARTER_TURN;
    end else begin
      phi = 25'(c_z);
    end
    theta = fo.x_neg ? (HALF_TURN - phi) : phi;
    h24   = fo.g_lt_b ? (FULL_TURN - theta) : theta;
    hr    = h24 + HUE_ROUND;
    if (fo.gray) begin
      hue_n = '0;
    end else if (hr[24]) begin
      hue_n = '1;
    end else begin
      hue_n = hr[23:8];
    end
    if (fo.sum_zero) begin
      sat_n = '0;
    end else if (fo.sat_full) begin
      sat_n = '1;
    end else begin
      sat_n = q_sat;
    end
    int_n = fo.int_sat ? '1 : q_int;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {int_n, sat_n, hue_n};
      m_tuser <= !fo.gray;
    end
  end

endmodule
